### design/mpd_pkg.sv
package mpd_pkg;

  localparam int LenW   = 28;
  localparam int TopicW = 16;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  localparam logic [2:0] EV_CONNACK  = 3'd0;
  localparam logic [2:0] EV_TOPIC    = 3'd1;
  localparam logic [2:0] EV_PAYLOAD  = 3'd2;
  localparam logic [2:0] EV_PUBEND   = 3'd3;
  localparam logic [2:0] EV_SUBACK   = 3'd4;
  localparam logic [2:0] EV_UNSUBACK = 3'd5;
  localparam logic [2:0] EV_PINGRESP = 3'd6;
  localparam logic [2:0] EV_ERROR    = 3'd7;

  localparam logic [7:0] ERR_LONG      = 8'd0;
  localparam logic [7:0] ERR_BIG       = 8'd1;
  localparam logic [7:0] ERR_MALFORMED = 8'd2;

  localparam logic [3:0] TYPE_CONNACK  = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
  localparam logic [3:0] TYPE_SUBACK   = 4'd9;
  localparam logic [3:0] TYPE_UNSUBACK = 4'd11;
  localparam logic [3:0] TYPE_PINGRESP = 4'd13;

  localparam logic       CMD_BYTE    = 1'b0;
  localparam logic       CMD_RESTART = 1'b1;

  localparam logic       REG_MAX_PACKET_LEN = 1'b0;
  localparam logic       REG_MAX_TOPIC_LEN  = 1'b1;

  localparam logic [LenW-1:0]   MAX_PACKET_LEN_RST = 28'd4096;
  localparam logic [TopicW-1:0] MAX_TOPIC_LEN_RST  = 16'd128;

  localparam logic [2:0] MAX_LEN_BYTES = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] event_res;
    logic [7:0] data;
    logic       end_of_packet;
  } result_t;

  typedef struct packed {
    logic [LenW-1:0]   max_packet_len;
    logic [TopicW-1:0] max_topic_len;
  } cfg_t;

  // report for packet types that only need the packet to end
  function automatic result_t simple_end(input logic [3:0] ptype);
    result_t r;
    r = '0;
    case (ptype)
      TYPE_SUBACK: begin
        r.valid = 1'b1;
        r.event_res = EV_SUBACK;
        r.end_of_packet = 1'b1;
      end
      TYPE_UNSUBACK: begin
        r.valid = 1'b1;
        r.event_res = EV_UNSUBACK;
        r.end_of_packet = 1'b1;
      end
      TYPE_PINGRESP: begin
        r.valid = 1'b1;
        r.event_res = EV_PINGRESP;
        r.end_of_packet = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic result_t make_res(input logic [2:0] ev, input logic [7:0] d,
                                       input logic eop);
    result_t r;
    r.valid = 1'b1;
    r.event_res = ev;
    r.data = d;
    r.end_of_packet = eop;
    return r;
  endfunction

endpackage

### design/mpd_in_reg.sv
module mpd_in_reg import mpd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  held,
  output item_t item
);

  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### design/mpd_cfg_regs.sv
module mpd_cfg_regs import mpd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [LenW-1:0] cfg_data,
  output cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_packet_len <= MAX_PACKET_LEN_RST;
      cfg.max_topic_len <= MAX_TOPIC_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_PACKET_LEN: cfg.max_packet_len <= cfg_data;
        REG_MAX_TOPIC_LEN:  cfg.max_topic_len <= cfg_data[TopicW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/mpd_parser.sv
module mpd_parser import mpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [1:0]        phase, phase_next;
  logic [7:0]        fixed_header, fixed_header_next;
  logic [LenW-1:0]   remaining_length, remaining_length_next;
  logic [2:0]        length_byte_count, length_byte_count_next;
  logic [LenW-1:0]   body_position, body_position_next;
  logic [TopicW-1:0] topic_length, topic_length_next;
  logic [7:0]        connack_code, connack_code_next;

  logic [3:0]        ptype;
  logic [7:0]        b;
  logic [LenW:0]     pos_inc;
  logic              last;
  logic [LenW-1:0]   len_add;
  logic [LenW-1:0]   len_sum;
  logic [2:0]        count_inc;
  logic [TopicW-1:0] tl_full;
  logic [1:0]        qos_extra;
  logic [TopicW:0]   topic_end;
  logic [TopicW+1:0] pid_end;
  logic [TopicW:0]   topic_end_new;
  logic [TopicW+1:0] pid_end_new;

  assign ptype = fixed_header[7:4];
  assign b = item.data_byte;
  assign pos_inc = {1'b0, body_position} + {{LenW{1'b0}}, 1'b1};
  assign last = pos_inc == {1'b0, remaining_length};
  assign count_inc = length_byte_count + 3'd1;
  assign qos_extra = (fixed_header[2:1] != 2'b00) ? 2'd2 : 2'd0;
  assign tl_full = {topic_length[15:8], b};
  assign topic_end = {1'b0, topic_length} + 17'd2;
  assign pid_end = {1'b0, topic_end} + {16'd0, qos_extra};
  assign topic_end_new = {1'b0, tl_full} + 17'd2;
  assign pid_end_new = {1'b0, topic_end_new} + {16'd0, qos_extra};

  always_comb begin
    case (length_byte_count[1:0])
      2'd0:    len_add = {21'd0, b[6:0]};
      2'd1:    len_add = {14'd0, b[6:0], 7'd0};
      2'd2:    len_add = {7'd0, b[6:0], 14'd0};
      default: len_add = {b[6:0], 21'd0};
    endcase
    len_sum = remaining_length + len_add;
  end

  always_comb begin
    phase_next = phase;
    fixed_header_next = fixed_header;
    remaining_length_next = remaining_length;
    length_byte_count_next = length_byte_count;
    body_position_next = body_position;
    topic_length_next = topic_length;
    connack_code_next = connack_code;
    res = '0;

    if (item.command == CMD_RESTART) begin
      phase_next = PH_HEADER;
      fixed_header_next = '0;
      remaining_length_next = '0;
      length_byte_count_next = '0;
      body_position_next = '0;
      topic_length_next = '0;
      connack_code_next = '0;
    end else begin
      case (phase)
        PH_HEADER: begin
          fixed_header_next = b;
          remaining_length_next = '0;
          length_byte_count_next = '0;
          body_position_next = '0;
          topic_length_next = '0;
          connack_code_next = '0;
          phase_next = PH_LENGTH;
        end
        PH_LENGTH: begin
          remaining_length_next = len_sum;
          length_byte_count_next = count_inc;
          if (b[7]) begin
            if (count_inc >= MAX_LEN_BYTES) begin
              phase_next = PH_ERROR;
              res = make_res(EV_ERROR, ERR_LONG, 1'b1);
            end
          end else if (len_sum > cfg.max_packet_len) begin
            phase_next = PH_ERROR;
            res = make_res(EV_ERROR, ERR_BIG, 1'b1);
          end else begin
            body_position_next = '0;
            if (len_sum != '0) begin
              phase_next = PH_BODY;
            end else if (ptype == TYPE_CONNACK || ptype == TYPE_PUBLISH) begin
              phase_next = PH_ERROR;
              res = make_res(EV_ERROR, ERR_MALFORMED, 1'b1);
            end else begin
              phase_next = PH_HEADER;
              res = simple_end(ptype);
            end
          end
        end
        PH_BODY: begin
          body_position_next = pos_inc[LenW-1:0];
          if (last) begin
            phase_next = PH_HEADER;
          end
          if (ptype == TYPE_CONNACK) begin
            if (body_position == 28'd1) begin
              connack_code_next = b;
            end
            if (last) begin
              if (remaining_length < 28'd2) begin
                phase_next = PH_ERROR;
                res = make_res(EV_ERROR, ERR_MALFORMED, 1'b1);
              end else begin
                res = make_res(EV_CONNACK, connack_code_next, 1'b1);
              end
            end
          end else if (ptype == TYPE_PUBLISH) begin
            if (body_position == 28'd0) begin
              topic_length_next = {b, 8'd0};
              if (last) begin
                phase_next = PH_ERROR;
                res = make_res(EV_ERROR, ERR_MALFORMED, 1'b1);
              end
            end else if (body_position == 28'd1) begin
              topic_length_next = tl_full;
              if (tl_full > cfg.max_topic_len ||
                  {10'd0, pid_end_new} > remaining_length) begin
                phase_next = PH_ERROR;
                res = make_res(EV_ERROR, ERR_MALFORMED, 1'b1);
              end else if (last) begin
                res = make_res(EV_PUBEND, 8'd0, 1'b1);
              end
            end else if (body_position < {11'd0, topic_end}) begin
              res = make_res(EV_TOPIC, b, last);
            end else if (body_position < {10'd0, pid_end}) begin
              if (last) begin
                res = make_res(EV_PUBEND, 8'd0, 1'b1);
              end
            end else begin
              res = make_res(EV_PAYLOAD, b, last);
            end
          end else if (last) begin
            res = simple_end(ptype);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      fixed_header <= '0;
      remaining_length <= '0;
      length_byte_count <= '0;
      body_position <= '0;
      topic_length <= '0;
      connack_code <= '0;
    end else if (step) begin
      phase <= phase_next;
      fixed_header <= fixed_header_next;
      remaining_length <= remaining_length_next;
      length_byte_count <= length_byte_count_next;
      body_position <= body_position_next;
      topic_length <= topic_length_next;
      connack_code <= connack_code_next;
    end
  end

endmodule

### design/mpd_out_reg.sv
module mpd_out_reg import mpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [7:0] data,
  output logic       end_of_packet
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      event_res <= res.event_res;
      data <= res.data;
      end_of_packet <= res.end_of_packet;
    end
  end

endmodule

### design/mqtt_packet_decoder_core.sv
// mqtt packet decoder core
// input channel: in_valid/in_ready with command and data_byte; command 0 feeds
// one stream byte, command 1 restarts the parser and clears a sticky error
// output channel: out_valid/out_ready with event_res, data and end_of_packet;
// a byte gives at most one result
// config channel: cfg_valid/cfg_ready with cfg_index (0 max_packet_len,
// 1 max_topic_len) and cfg_data; cfg_ready is always high, write only when idle
// order: a request is registered in the input register on acceptance and is
// decoded once the output register is free; any result is registered there
// throughput: one request per cycle while out_ready does not stall the output,
// with a combinational parser step between the input and output registers
// reset: parser returns to the fixed header phase, limits go to 4096 and 128,
// both channel registers empty
// stall: while a result waits on out_ready the parser holds; the input register
// keeps one request and in_ready drops once it is full
module mqtt_packet_decoder_core import mpd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            command,
  input  logic [7:0]      data_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      event_res,
  output logic [7:0]      data,
  output logic            end_of_packet,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [LenW-1:0] cfg_data
);

  item_t   in_item;
  item_t   item;
  logic    held;
  logic    free;
  logic    step;
  cfg_t    cfg;
  result_t res;

  assign in_item.command = command;
  assign in_item.data_byte = data_byte;
  assign step = held && free;

  mpd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step),
    .held     (held),
    .item     (item)
  );

  mpd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mpd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  mpd_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .res           (res),
    .free          (free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .data          (data),
    .end_of_packet (end_of_packet)
  );

endmodule
